FILE: sv/ubb_pkg.sv
package ubb_pkg;

  // Spline order and column budget.
  localparam int DEGREE        = 3;
  localparam int MAX_INTERVALS = 61;
  localparam int COL_LIMIT     = 64;
  localparam int IVAL_LIMIT    = (MAX_INTERVALS < COL_LIMIT - DEGREE) ?
                                 MAX_INTERVALS : COL_LIMIT - DEGREE;
  localparam int NODES         = DEGREE + 1;
  localparam int PAIRS         = (DEGREE > 0) ? DEGREE : 1;

  // Field widths.
  localparam int DATA_W    = 32;
  localparam int COL_W     = 6;
  localparam int VAL_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int DIFF_W    = COL_W + 1;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);

  // Division by the step number is a multiply by a rounded-up reciprocal.
  // The quotient is exact for dividends below 2**T_W and steps up to five.
  localparam int RECIP_SHIFT = 22;
  localparam int T_W         = 19;
  localparam logic [RECIP_SHIFT:0] RECIP [8] = '{
    (RECIP_SHIFT+1)'(0),
    (RECIP_SHIFT+1)'((2**RECIP_SHIFT + 0) / 1),
    (RECIP_SHIFT+1)'((2**RECIP_SHIFT + 1) / 2),
    (RECIP_SHIFT+1)'((2**RECIP_SHIFT + 2) / 3),
    (RECIP_SHIFT+1)'((2**RECIP_SHIFT + 3) / 4),
    (RECIP_SHIFT+1)'((2**RECIP_SHIFT + 4) / 5),
    (RECIP_SHIFT+1)'(0),
    (RECIP_SHIFT+1)'(0)
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_EDGE      = 2'd0,
    REG_INV_SPACING    = 2'd1,
    REG_INTERVAL_COUNT = 2'd2
  } cfg_reg_t;

  // Configuration as seen by the datapath; ivals is already clamped.
  typedef struct packed {
    logic signed [DATA_W-1:0] left_edge;
    logic [DATA_W-1:0]        inv_spacing;
    logic [COL_W-1:0]         ivals;
  } cfg_t;

  // Knot position of one sample.
  typedef struct packed {
    logic [COL_W-1:0]  c0;
    logic              hit;
    logic [FRAC_W-1:0] frac;
  } knot_t;

  // One output column in flight through the recursion steps.
  typedef struct packed {
    logic [COL_W-1:0]                  idx;
    logic                              last;
    logic [FRAC_W-1:0]                 frac;
    logic [NODES-1:0][DIFF_W-1:0]      diff;
    logic [NODES-1:0][VAL_W-1:0]       bv;
  } col_t;

endpackage

FILE: sv/ubb_if.sv
interface ubb_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [ubb_pkg::DATA_W-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface ubb_basis_if;
  logic                       valid;
  logic                       ready;
  logic [ubb_pkg::COL_W-1:0]  basis_index;
  logic [ubb_pkg::VAL_W-1:0]  basis_value;
  logic                       last;

  modport source(output valid, output basis_index, output basis_value, output last,
                 input ready);
  modport sink(input valid, input basis_index, input basis_value, input last,
               output ready);
endinterface

FILE: sv/ubb_knot.sv
module ubb_knot (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ubb_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ubb_pkg::DATA_W-1:0] in_sample,
  output logic                              knot_valid,
  input  logic                              knot_ready,
  output ubb_pkg::knot_t                    knot
);
  import ubb_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic r1, r2, r3, r4, r5, r6;

  logic signed [DATA_W:0] diff1_r;
  logic                   neg2_r;
  logic [DATA_W:0]        mag2_r;
  logic                   neg3_r;
  logic [DATA_W:0]        hh3_r, hl3_r;
  logic [DATA_W-1:0]      lh3_r, ll3_r;
  logic                   neg4_r;
  logic [2*DATA_W-1:0]    prod4_r;
  logic                   neg5_r;
  logic [2*DATA_W-17:0]   qv5_r;
  knot_t                  knot6_r;

  logic [DATA_W:0]        mag_nxt;
  logic [2*DATA_W-1:0]    prod_nxt;
  logic [2*DATA_W-17:0]   qv_nxt;
  knot_t                  knot_nxt;
  logic [DATA_W-1:0]      qi;
  logic [FRAC_W-1:0]      qf;
  logic                   fz;
  logic [COL_W:0]         nmag;

  // Each stage moves when it is empty or its successor moves.
  assign r6       = !v6_r || knot_ready;
  assign r5       = !v5_r || r6;
  assign r4       = !v4_r || r5;
  assign r3       = !v3_r || r4;
  assign r2       = !v2_r || r3;
  assign r1       = !v1_r || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
      if (r5) v5_r <= v4_r;
      if (r6) v6_r <= v5_r;
    end
  end

  // Magnitude of the offset from the left edge.
  assign mag_nxt = diff1_r[DATA_W] ? (DATA_W+1)'(-diff1_r) : (DATA_W+1)'(diff1_r);

  // Partial products are summed into the exact Q32.32 product.
  assign prod_nxt = ((2*DATA_W)'(hh3_r) << 32) + ((2*DATA_W)'(hl3_r) << 16) +
                    ((2*DATA_W)'(lh3_r) << 16) + (2*DATA_W)'(ll3_r);

  // Floor to Q32.16; a negative offset rounds its magnitude up.
  assign qv_nxt = prod4_r[2*DATA_W-1:16] +
                  (2*DATA_W-16)'(neg4_r && (prod4_r[15:0] != 16'd0));

  // Integer part, fraction and range check of the first column.
  always_comb begin
    qi   = qv5_r[2*DATA_W-17:16];
    qf   = qv5_r[15:0];
    fz   = (qf != 16'd0);
    nmag = {1'b0, qi[COL_W-1:0]} + (COL_W+1)'(fz);
    if (neg5_r) begin
      knot_nxt.hit  = (qi[DATA_W-1:COL_W] == '0) && (nmag <= (COL_W+1)'(DEGREE));
      knot_nxt.c0   = COL_W'((COL_W+1)'(DEGREE) - nmag);
      knot_nxt.frac = FRAC_W'(~qf + 16'd1);
    end else begin
      knot_nxt.hit  = (qi[DATA_W-1:COL_W] == '0) && (qi[COL_W-1:0] < cfg.ivals);
      knot_nxt.c0   = COL_W'(qi[COL_W-1:0] + COL_W'(DEGREE));
      knot_nxt.frac = qf;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (r1) begin
      diff1_r <= (DATA_W+1)'(in_sample) - (DATA_W+1)'(cfg.left_edge);
    end
    if (r2) begin
      neg2_r <= diff1_r[DATA_W];
      mag2_r <= mag_nxt;
    end
    if (r3) begin
      neg3_r <= neg2_r;
      hh3_r  <= mag2_r[DATA_W:16] * cfg.inv_spacing[31:16];
      hl3_r  <= mag2_r[DATA_W:16] * cfg.inv_spacing[15:0];
      lh3_r  <= mag2_r[15:0] * cfg.inv_spacing[31:16];
      ll3_r  <= mag2_r[15:0] * cfg.inv_spacing[15:0];
    end
    if (r4) begin
      neg4_r  <= neg3_r;
      prod4_r <= prod_nxt;
    end
    if (r5) begin
      neg5_r <= neg4_r;
      qv5_r  <= qv_nxt;
    end
    if (r6) begin
      knot6_r <= knot_nxt;
    end
  end

  assign knot_valid = v6_r;
  assign knot       = knot6_r;

endmodule

FILE: sv/ubb_issue.sv
module ubb_issue (
  input  logic           clk,
  input  logic           rst_n,
  input  ubb_pkg::cfg_t  cfg,
  input  logic           knot_valid,
  output logic           knot_ready,
  input  ubb_pkg::knot_t knot,
  output logic           col_valid,
  input  logic           col_ready,
  output ubb_pkg::col_t  col
);
  import ubb_pkg::*;

  logic             hold_r;
  knot_t            s_r;
  logic [COL_W-1:0] col_r;
  logic             ov_r;
  col_t             od_r;

  logic             o_free, issue, is_last, take;
  logic [COL_W:0]   m_w;
  logic [COL_W-1:0] mlast;
  logic [COL_W:0]   sum_w [NODES];
  logic [COL_W:0]   j_w   [NODES];
  col_t             col_nxt;

  // Column count of one row and the index of its last column.
  assign m_w   = {1'b0, cfg.ivals} + (COL_W+1)'(DEGREE);
  assign mlast = COL_W'(m_w - (COL_W+1)'(1));

  assign o_free     = !ov_r || col_ready;
  assign issue      = hold_r && o_free;
  assign is_last    = (col_r == mlast);
  assign knot_ready = !hold_r || (issue && is_last);
  assign take       = knot_valid && knot_ready;

  // Degree-0 indicators and knot offsets of the columns that feed this one.
  always_comb begin
    col_nxt.idx  = col_r;
    col_nxt.last = is_last;
    col_nxt.frac = s_r.frac;
    for (int i = 0; i < NODES; i++) begin
      sum_w[i] = {1'b0, col_r} + (COL_W+1)'(i);
      j_w[i]   = (sum_w[i] >= m_w) ? sum_w[i] - m_w : sum_w[i];
      col_nxt.diff[i] = {1'b0, s_r.c0} - {1'b0, j_w[i][COL_W-1:0]};
      col_nxt.bv[i]   = (s_r.hit && (j_w[i][COL_W-1:0] == s_r.c0)) ? ONE_Q16 : '0;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      ov_r   <= 1'b0;
      col_r  <= '0;
    end else begin
      if (take) begin
        hold_r <= 1'b1;
        col_r  <= '0;
      end else if (issue) begin
        if (is_last) hold_r <= 1'b0;
        col_r <= col_r + COL_W'(1);
      end
      if (o_free) ov_r <= issue;
    end
  end

  // Sample and column payload.
  always_ff @(posedge clk) begin
    if (take) s_r <= knot;
    if (issue) od_r <= col_nxt;
  end

  assign col_valid = ov_r;
  assign col       = od_r;

endmodule

FILE: sv/ubb_step.sv
module ubb_step (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ubb_pkg::STEP_W-1:0] step_k,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ubb_pkg::col_t              in_col,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ubb_pkg::col_t              out_col
);
  import ubb_pkg::*;

  logic va_r, vb_r, vc_r;
  logic ra, rb, rc;

  col_t                     da_r, db_r, oc_r;
  logic signed [40:0]       pa_r [PAIRS];
  logic signed [41:0]       qa_r [PAIRS];
  logic [PAIRS-1:0]         zb_r, sb_r;
  logic [T_W-1:0]           tb_r [PAIRS];

  logic [STEP_W-1:0]        kp1;
  logic signed [23:0]       base_w;
  logic signed [22:0]       p_w   [PAIRS];
  logic signed [23:0]       q_w   [PAIRS];
  logic signed [40:0]       pp_nxt [PAIRS];
  logic signed [41:0]       qp_nxt [PAIRS];
  logic signed [42:0]       s_w   [PAIRS];
  logic signed [42:0]       rnd_w [PAIRS];
  logic [26:0]              t_w   [PAIRS];
  logic [PAIRS-1:0]         z_nxt, s_nxt;
  logic [T_W+RECIP_SHIFT:0] m_w   [PAIRS];
  col_t                     oc_nxt;

  assign rc       = !vc_r || out_ready;
  assign rb       = !vb_r || rc;
  assign ra       = !va_r || rb;
  assign in_ready = ra;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ra) va_r <= in_valid;
      if (rb) vb_r <= va_r;
      if (rc) vc_r <= vb_r;
    end
  end

  // Stage A: weights P and (k+1-P) times the two neighbor values.
  assign kp1    = step_k + STEP_W'(1);
  assign base_w = $signed({5'b0, kp1, 16'b0});

  always_comb begin
    for (int i = 0; i < PAIRS; i++) begin
      p_w[i]    = '0;
      q_w[i]    = '0;
      pp_nxt[i] = '0;
      qp_nxt[i] = '0;
    end
    for (int i = 0; i < DEGREE; i++) begin
      p_w[i]    = $signed({in_col.diff[i], in_col.frac});
      q_w[i]    = base_w - {p_w[i][22], p_w[i]};
      pp_nxt[i] = p_w[i] * $signed({1'b0, in_col.bv[i]});
      qp_nxt[i] = q_w[i] * $signed({1'b0, in_col.bv[i+1]});
    end
  end

  // Stage B: sum, round half up, scale out Q16, flag the clamp cases.
  always_comb begin
    for (int i = 0; i < PAIRS; i++) begin
      s_w[i]   = 43'(pa_r[i]) + 43'(qa_r[i]);
      rnd_w[i] = s_w[i] + $signed({25'b0, step_k, 15'b0});
      t_w[i]   = rnd_w[i][42:16];
      z_nxt[i] = s_w[i][42] || (s_w[i] == '0);
      s_nxt[i] = (t_w[i] >= {8'b0, step_k, 16'b0});
    end
  end

  // Stage C: divide by k through the reciprocal and clamp to 0..1.0.
  always_comb begin
    oc_nxt = db_r;
    for (int i = 0; i < PAIRS; i++) begin
      m_w[i] = tb_r[i] * RECIP[step_k];
    end
    for (int i = 0; i < DEGREE; i++) begin
      if (zb_r[i]) begin
        oc_nxt.bv[i] = '0;
      end else if (sb_r[i]) begin
        oc_nxt.bv[i] = ONE_Q16;
      end else begin
        oc_nxt.bv[i] = m_w[i][RECIP_SHIFT +: VAL_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ra) begin
      da_r <= in_col;
      pa_r <= pp_nxt;
      qa_r <= qp_nxt;
    end
    if (rb) begin
      db_r <= da_r;
      zb_r <= z_nxt;
      sb_r <= s_nxt;
      for (int i = 0; i < PAIRS; i++) begin
        tb_r[i] <= t_w[i][T_W-1:0];
      end
    end
    if (rc) begin
      oc_r <= oc_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_col   = oc_r;

endmodule

FILE: sv/uniform_bspline_basis_eval.sv
// Uniform B-spline basis evaluator: each sample accepted on in_ch (signed
// Q16.16) produces one design-matrix row on out_ch, M = interval_count + DEGREE
// transfers in column order, each carrying the column index, the basis value
// in unsigned Q16 (65536 is 1.0) and a last flag on column M-1. The column
// sequencer issues one column per clock while the result channel accepts, and
// takes the next sample only with the last column of the current row; a
// six-stage knot-position pipeline ahead of the sequencer holds further
// samples. Configuration (left_edge, inverse_spacing, interval_count) goes
// through cfg_we/cfg_index/cfg_data; the user must write it only while no row
// is in flight, which the block does not enforce. Only the low six bits of
// interval_count are kept; a zero acts as one and values above 61 saturate.
module uniform_bspline_basis_eval (
  input  logic                                clk,
  input  logic                                rst_n,
  ubb_sample_if.sink                          in_ch,
  ubb_basis_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [ubb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ubb_pkg::DATA_W-1:0]          cfg_data
);
  import ubb_pkg::*;

  logic signed [DATA_W-1:0] left_edge_r;
  logic [DATA_W-1:0]        inv_spacing_r;
  logic [COL_W-1:0]         interval_count_r;
  logic [COL_W-1:0]         ivals;
  cfg_t                     cfg;

  logic                     knot_valid, knot_ready;
  knot_t                    knot;
  col_t                     chain_col   [NODES];
  logic [DEGREE:0]          chain_valid;
  logic [DEGREE:0]          chain_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_edge_r      <= '0;
      inv_spacing_r    <= DATA_W'(65536);
      interval_count_r <= COL_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEFT_EDGE:      left_edge_r      <= cfg_data;
        REG_INV_SPACING:    inv_spacing_r    <= cfg_data;
        REG_INTERVAL_COUNT: interval_count_r <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Interval count clamped to the supported range.
  always_comb begin
    if (interval_count_r == '0) begin
      ivals = COL_W'(1);
    end else if (interval_count_r > COL_W'(IVAL_LIMIT)) begin
      ivals = COL_W'(IVAL_LIMIT);
    end else begin
      ivals = interval_count_r;
    end
  end

  assign cfg.left_edge   = left_edge_r;
  assign cfg.inv_spacing = inv_spacing_r;
  assign cfg.ivals       = ivals;

  // Knot position of each sample.
  ubb_knot u_knot (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.sample),
    .knot_valid (knot_valid),
    .knot_ready (knot_ready),
    .knot       (knot)
  );

  // One column per clock, while the step chain accepts, with its degree-0 indicators.
  ubb_issue u_issue (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .knot_valid (knot_valid),
    .knot_ready (knot_ready),
    .knot       (knot),
    .col_valid  (chain_valid[0]),
    .col_ready  (chain_ready[0]),
    .col        (chain_col[0])
  );

  // One recursion step per degree.
  for (genvar s = 0; s < DEGREE; s++) begin : g_step
    ubb_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_k    (STEP_W'(s + 1)),
      .in_valid  (chain_valid[s]),
      .in_ready  (chain_ready[s]),
      .in_col    (chain_col[s]),
      .out_valid (chain_valid[s+1]),
      .out_ready (chain_ready[s+1]),
      .out_col   (chain_col[s+1])
    );
  end

  assign out_ch.valid        = chain_valid[DEGREE];
  assign chain_ready[DEGREE] = out_ch.ready;
  assign out_ch.basis_index  = chain_col[DEGREE].idx;
  assign out_ch.basis_value  = chain_col[DEGREE].bv[0];
  assign out_ch.last         = chain_col[DEGREE].last;

`ifndef ASSERT_OFF
  // Every value leaving the block is clamped to 0..1.0.
  a_value_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.basis_value <= ONE_Q16))
    else $error("basis value above 1.0");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

FILE: bench/ubb_row_checker.sv
// Watches both channels and the register port of the basis evaluator.
// Every accepted sample is turned into its expected design-matrix row,
// and every column transfer is compared against the oldest expectation.
module ubb_row_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  ubb_sample_if                         in_mon,
  ubb_basis_if                          out_mon,
  input  logic                          cfg_we,
  input  logic [ubb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ubb_pkg::DATA_W-1:0]    cfg_data,
  output int unsigned                   fail_count,
  output int unsigned                   cols_pending,
  output int unsigned                   cols_checked
);
  import ubb_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
  } basis_col_t;

  // Local copy of the register file.
  logic signed [DATA_W-1:0] left_edge_q;
  logic [DATA_W-1:0]        inv_spacing_q;
  logic [COL_W-1:0]         interval_count_q;

  basis_col_t expected_cols[$];
  int unsigned errors = 0;
  int unsigned compared = 0;

  // Division by k*1.0 rounded half up, then clamped into 0..1.0.
  function automatic longint round_clamp(input longint num, input longint den);
    longint v;
    if (num <= 0) return 0;
    v = (num + den / 2) / den;
    return (v > 65536) ? 65536 : v;
  endfunction

  // Works out the full basis row for one sample and queues its columns.
  task automatic push_basis_row(input logic signed [DATA_W-1:0] sample);
    longint     bv[COL_LIMIT];
    longint     nv[COL_LIMIT];
    longint     diff, ipart, frac, c0, p, q, num;
    bit [63:0]  mag, prod, qq, qi, qf;
    int         ivals, m, nx;
    basis_col_t col;

    ivals = int'(interval_count_q);
    if (ivals < 1) ivals = 1;
    if (ivals > IVAL_LIMIT) ivals = IVAL_LIMIT;
    m = ivals + DEGREE;

    // Knot position: exact product, floored to Q32.16.
    diff = longint'(sample) - longint'(left_edge_q);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * {32'd0, inv_spacing_q};
    if (diff >= 0) begin
      ipart = longint'(prod >> 32);
      frac  = longint'((prod >> 16) & 64'hFFFF);
    end else begin
      qq = (prod >> 16) + ((prod[15:0] != 16'd0) ? 64'd1 : 64'd0);
      qi = qq >> 16;
      qf = qq & 64'hFFFF;
      if (qf == 64'd0) begin
        ipart = -longint'(qi);
        frac  = 0;
      end else begin
        ipart = -longint'(qi) - 1;
        frac  = 65536 - longint'(qf);
      end
    end
    c0 = ipart + DEGREE;

    for (int c = 0; c < COL_LIMIT; c++) bv[c] = 0;

    // Cox-de Boor steps; the last column wraps to column 0.
    if (c0 >= 0 && c0 < m) begin
      bv[c0] = 65536;
      for (int k = 1; k <= DEGREE; k++) begin
        for (int c = 0; c < m; c++) begin
          nx    = (c + 1 < m) ? c + 1 : 0;
          p     = (c0 - c) * 65536 + frac;
          q     = (k + 1) * 65536 - p;
          num   = p * bv[c] + q * bv[nx];
          nv[c] = round_clamp(num, k * 65536);
        end
        for (int c = 0; c < m; c++) bv[c] = nv[c];
      end
    end

    for (int c = 0; c < m; c++) begin
      col.index = COL_W'(c);
      col.value = VAL_W'(bv[c]);
      col.last  = (c == m - 1);
      expected_cols.push_back(col);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned col_no,
                                      input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: column %0d, %s expected %0d, got %0d",
               $time, col_no, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin : row_tracking
    basis_col_t exp_col;
    if (!rst_n) begin
      left_edge_q      <= '0;
      inv_spacing_q    <= 32'd65536;
      interval_count_q <= 6'd16;
      expected_cols.delete();
    end else begin
      // Register writes; only the low six bits of the interval count are kept.
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LEFT_EDGE:      left_edge_q      <= cfg_data;
          REG_INV_SPACING:    inv_spacing_q    <= cfg_data;
          REG_INTERVAL_COUNT: interval_count_q <= cfg_data[COL_W-1:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) push_basis_row(in_mon.sample);

      // Each column transfer must match the oldest expected column.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_cols.size() == 0) begin
          errors++;
          $display("%0t: column transfer with no row pending: index %0d value %0d last %0d",
                   $time, out_mon.basis_index, out_mon.basis_value, out_mon.last);
        end else begin
          exp_col = expected_cols.pop_front();
          check_field("basis_index", compared, longint'(exp_col.index),
                      longint'(out_mon.basis_index));
          check_field("basis_value", compared, longint'(exp_col.value),
                      longint'(out_mon.basis_value));
          check_field("last", compared, longint'(exp_col.last), longint'(out_mon.last));
          compared++;
        end
      end
    end
    cols_pending <= expected_cols.size();
    fail_count   <= errors;
    cols_checked <= compared;
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import ubb_pkg::*;

  localparam int DRAIN_CYCLES   = 7 + 3 * DEGREE + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_SAMPLES  = 16;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_style_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  ubb_sample_if in_ch();
  ubb_basis_if  out_ch();

  int unsigned fail_count, cols_pending, cols_checked;

  // What the stimulus last wrote, used to aim samples into the knot grid.
  logic signed [DATA_W-1:0] cur_left;
  logic [DATA_W-1:0]        cur_inv;
  int                       cur_ivals;
  int unsigned              settings_used = 0;
  int unsigned              samples_sent = 0;

  idle_style_t src_style = IDLE_LIGHT;
  idle_style_t snk_style = IDLE_HEAVY;
  int unsigned quiet_cycles = 0;
  int unsigned quiet_stall = 0;

  uniform_bspline_basis_eval dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ubb_row_checker row_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .cols_pending (cols_pending),
    .cols_checked (cols_checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned draw_wait(input idle_style_t style);
    case (style)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
      default:    return $urandom_range(0, 13);
    endcase
  endfunction

  // Result side: after each transfer, hold ready low for a drawn stall.
  always @(posedge clk) begin : sink_pacing
    int unsigned n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_ch.ready) begin
      if (out_ch.valid) begin
        n = draw_wait(snk_style);
        if (n != 0) begin
          out_ch.ready <= 1'b0;
          quiet_stall  = n;
        end
      end
    end else if (quiet_stall > 1) begin
      quiet_stall = quiet_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Ends the run if nothing moves for too long.
  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we ||
        !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d columns still expected",
               $time, WATCHDOG_LIMIT, cols_pending);
      $display("uniform_bspline_basis_eval: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes all three registers on consecutive edges.
  task automatic write_config(input logic [DATA_W-1:0] le, input logic [DATA_W-1:0] inv,
                              input logic [DATA_W-1:0] ic_word);
    int ic;
    cfg_we    <= 1'b1;
    cfg_index <= REG_LEFT_EDGE;
    cfg_data  <= le;
    @(posedge clk);
    cfg_index <= REG_INV_SPACING;
    cfg_data  <= inv;
    @(posedge clk);
    cfg_index <= REG_INTERVAL_COUNT;
    cfg_data  <= ic_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ic = int'(ic_word[COL_W-1:0]);
    cur_left  = le;
    cur_inv   = inv;
    cur_ivals = (ic < 1) ? 1 : ((ic > IVAL_LIMIT) ? IVAL_LIMIT : ic);
    settings_used++;
  endtask

  // Presents one sample after a drawn gap and returns at its transfer edge.
  task automatic send_sample(input logic [DATA_W-1:0] s);
    int unsigned gap;
    gap = draw_wait(src_style);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  // Lets every queued column drain, then waits out the pipeline.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cols_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Picks a sample whose knot position lands near or inside the grid.
  function automatic logic [DATA_W-1:0] aimed_sample();
    longint u, off;
    if (cur_inv == '0 || $urandom_range(0, 4) == 0) return $urandom;
    u   = longint'($urandom_range(0, (cur_ivals + DEGREE + 2) * 65536)) -
          longint'((DEGREE + 1) * 65536);
    off = (u <<< 16) / longint'({32'd0, cur_inv});
    return DATA_W'(longint'(cur_left) + off);
  endfunction

  initial begin : stimulus
    logic [DATA_W-1:0] le, inv, ic_word;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_LEFT_EDGE;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cur_left     = '0;
    cur_inv      = 32'd65536;
    cur_ivals    = 16;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: unit spacing from zero, nineteen columns.
    send_sample(32'h0000_0000);
    send_sample(32'h0000_8000);
    send_sample(32'hFFFF_FFFF);   // one step below zero
    send_sample(32'hFFFF_8000);
    send_sample(32'hFFFD_0000);   // indicator on column 0
    send_sample(32'hFFFD_4000);
    send_sample(32'hFFFC_0001);   // just left of the grid
    send_sample(32'hFFFC_0000);
    send_sample(32'h000F_C000);   // indicator on the last column, wraps to column 0
    send_sample(32'h0010_0000);   // just right of the grid
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0007_1234);
    wait_drained();

    // Extreme registers: zero intervals act as one, full-scale spacing.
    write_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFE);
    wait_drained();

    // Zero spacing pins every sample to one knot; widest row.
    write_config(32'h8000_0000, 32'h0000_0000, 32'd63);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
    wait_drained();

    // Widest row at unit spacing: both ends of the column range.
    write_config(32'h0000_0000, 32'h0001_0000, 32'd61);
    send_sample(32'h003C_FFFF);
    send_sample(32'hFFFD_0000);
    wait_drained();

    // Random settings, each with its own pacing; the first runs flat out.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        src_style = IDLE_NONE;
        snk_style = IDLE_NONE;
      end else begin
        src_style = idle_style_t'($urandom_range(0, 2));
        snk_style = idle_style_t'($urandom_range(0, 2));
      end
      le = ($urandom_range(0, 3) == 0) ? $urandom :
           DATA_W'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      case ($urandom_range(0, 9))
        0:       inv = $urandom;
        1:       inv = 32'h0000_0000;
        2:       inv = 32'hFFFF_FFFF;
        default: inv = $urandom_range(32'h0000_4000, 32'h0008_0000);
      endcase
      ic_word = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
      if ($urandom_range(0, 1) == 1) ic_word[DATA_W-1:COL_W] = (DATA_W-COL_W)'($urandom);
      write_config(le, inv, ic_word);
      repeat (PHASE_SAMPLES) send_sample(aimed_sample());
      wait_drained();
    end

    $display("Ran %0d samples under %0d register settings (plus reset values);",
             samples_sent, settings_used);
    $display("%0d columns compared.", cols_checked);
    if (fail_count == 0 && cols_pending == 0) begin
      $display("uniform_bspline_basis_eval: match");
    end else begin
      $display("%0d field errors, %0d columns never arrived", fail_count, cols_pending);
      $display("uniform_bspline_basis_eval: mismatch");
    end
    $finish;
  end

endmodule
